// ----- src/hex_integer_formatter_unit_assert.svh -----
// ----------------------------------------------------------------------------
// hex integer formatter assertion macros
// shared concurrent assertion forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef HEX_INTEGER_FORMATTER_UNIT_ASSERT_SVH
`define HEX_INTEGER_FORMATTER_UNIT_ASSERT_SVH

// same-cycle implication
`define HIF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HIF_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/hif_pkg.sv -----
// ----------------------------------------------------------------------------
// hif_pkg
// types, character codes and helpers shared by the hex formatter blocks
// ----------------------------------------------------------------------------
package hif_pkg;

   // ascii codes
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] CH_UPPER_X = 8'h58;

   // most characters one value may produce
   localparam logic [6:0] OUT_LIMIT = 7'd64;

   // job queue between front and back
   localparam int Q_DEPTH = 2;

   // one formatting job: segment counts in print order
   typedef struct packed {
      logic [31:0] value;
      logic        upper;
      logic        lead_space;
      logic [5:0]  sp_cnt;
      logic [1:0]  pfx_cnt;
      logic [5:0]  zp_cnt;
      logic [5:0]  pz_cnt;
      logic [3:0]  dig_cnt;
      logic [5:0]  tr_cnt;
      logic [6:0]  total;
   } hif_desc_type;

   typedef enum logic {
      BK_IDLE,
      BK_EMIT
   } bk_state_type;

   // one hex nibble as an ascii digit
   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      logic [7:0] base;
      begin
         base = upper ? CH_UPPER_A : CH_LOWER_A;
         if (nib >= 4'd10) begin
            hex_char = base + {4'd0, nib} - 8'd10;
         end else begin
            hex_char = CH_ZERO + {4'd0, nib};
         end
      end
   endfunction

endpackage

// ----- src/hif_channel_if.sv -----
// ----------------------------------------------------------------------------
// hif channel interfaces
// valid/ready channels for request beats and character beats
// ----------------------------------------------------------------------------
interface hif_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic        upper_case;
   logic        alternate_form;
   logic        zero_pad;
   logic        left_justify;
   logic        space_flag;
   logic [5:0]  field_width;
   logic        precision_given;
   logic [5:0]  min_digits;

   modport source (
      output valid, value, upper_case, alternate_form, zero_pad, left_justify,
             space_flag, field_width, precision_given, min_digits,
      input  ready
   );
   modport sink (
      input  valid, value, upper_case, alternate_form, zero_pad, left_justify,
             space_flag, field_width, precision_given, min_digits,
      output ready
   );
endinterface

interface hif_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, character, last, input ready);
   modport sink (input valid, character, last, output ready);
endinterface

// ----- src/hex_integer_formatter_unit.sv -----
// a request beat is written to the job queue, loaded into the sequencer, then registered as the first character beat
// a value of N characters then streams at one beat per cycle while the sink is ready
// N is at most 64; the sequencer's one-character-per-cycle output sets the rate
// a 2-entry job queue takes new requests while the sequencer is busy
// synchronous active-high reset empties the queue, sequencer and output register
// ----------------------------------------------------------------------------
// hex_integer_formatter_unit
// printf-style hexadecimal formatter, one ascii character per output beat
// ----------------------------------------------------------------------------
module hex_integer_formatter_unit #(
   parameter int MAX_WIDTH     = 63,
   parameter int MAX_PRECISION = 60
) (
   input  logic       clock,
   input  logic       reset,
   hif_req_if.sink    req_chan,
   hif_rsp_if.source  rsp_chan
);
   import hif_pkg::*;

   logic         q_full;
   logic         q_push;
   hif_desc_type push_desc;
   logic         q_pop;
   logic         q_valid;
   hif_desc_type pop_desc;

   // classify request beats
   hif_front #(
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_PRECISION (MAX_PRECISION)
   ) u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_desc   (push_desc)
   );

   // job queue
   hif_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_desc  (pop_desc)
   );

   // character sequencer
   hif_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_desc   (pop_desc),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- src/hif_front.sv -----
// ----------------------------------------------------------------------------
// hif_front
// accepts request beats and works out the segment lengths of the text
// ----------------------------------------------------------------------------
module hif_front #(
   parameter int MAX_WIDTH     = 63,
   parameter int MAX_PRECISION = 60
) (
   hif_req_if.sink              req_chan,
   input  logic                 q_full,
   output logic                 q_push,
   output hif_pkg::hif_desc_type q_desc
);
   import hif_pkg::*;

   logic [5:0] w_sat;
   logic [5:0] p_sat;
   logic [5:0] p_eff;
   logic [3:0] nd_raw;
   logic [3:0] nd;
   logic       v_nz;
   logic       empty;
   logic       prefix;
   logic [5:0] pz;
   logic [6:0] len;
   logic [5:0] pad;
   logic       lsp;
   logic [5:0] sp;
   logic [5:0] zp;
   logic [5:0] tr;
   logic [7:0] total;

   assign req_chan.ready = !q_full;

   // bound width and precision
   always_comb begin
      w_sat = ({2'b00, req_chan.field_width} > 8'(MAX_WIDTH)) ? 6'(MAX_WIDTH)
                                                            : req_chan.field_width;
      p_sat = ({2'b00, req_chan.min_digits} > 8'(MAX_PRECISION)) ? 6'(MAX_PRECISION)
                                                               : req_chan.min_digits;
      p_eff = req_chan.precision_given ? p_sat : 6'd0;
   end

   // significant digit count from the highest nonzero nibble
   always_comb begin
      nd_raw = 4'd1;
      for (int i = 1; i < 8; i++) begin
         if (req_chan.value[i*4 +: 4] != 4'd0) begin
            nd_raw = 4'(i + 1);
         end
      end
   end

   // segment lengths
   always_comb begin
      v_nz   = (req_chan.value != 32'd0);
      empty  = req_chan.precision_given && (p_eff == 6'd0) && !v_nz;
      nd     = empty ? 4'd0 : nd_raw;
      prefix = req_chan.alternate_form && v_nz;
      pz     = (p_eff > {2'b00, nd}) ? (p_eff - {2'b00, nd}) : 6'd0;
      len    = {3'b000, nd} + {1'b0, pz} + (prefix ? 7'd2 : 7'd0);
      pad    = ({1'b0, w_sat} > len) ? 6'({1'b0, w_sat} - len) : 6'd0;
      lsp    = req_chan.space_flag && v_nz;
      if (req_chan.left_justify) begin
         sp = 6'd0;
         zp = 6'd0;
         tr = pad;
      end else begin
         sp = req_chan.zero_pad ? 6'd0 : pad;
         zp = (req_chan.zero_pad && !empty) ? pad : 6'd0;
         tr = 6'd0;
      end
      total = {7'd0, lsp} + {2'b00, sp} + {2'b00, zp} + {2'b00, tr} + {1'b0, len};
   end

   // job descriptor, empty text is dropped here
   always_comb begin
      q_desc.value      = req_chan.value;
      q_desc.upper      = req_chan.upper_case;
      q_desc.lead_space = lsp;
      q_desc.sp_cnt     = sp;
      q_desc.pfx_cnt    = prefix ? 2'd2 : 2'd0;
      q_desc.zp_cnt     = zp;
      q_desc.pz_cnt     = pz;
      q_desc.dig_cnt    = nd;
      q_desc.tr_cnt     = tr;
      q_desc.total      = (total > {1'b0, OUT_LIMIT}) ? OUT_LIMIT : total[6:0];
      q_push            = req_chan.valid && !q_full && (total != 8'd0);
   end

endmodule

// ----- src/hif_queue.sv -----
// ----------------------------------------------------------------------------
// hif_queue
// short job queue between the front classifier and the character sequencer
// ----------------------------------------------------------------------------
module hif_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hif_pkg::hif_desc_type push_desc,
   output logic                  full,
   input  logic                  pop,
   output logic                  pop_valid,
   output hif_pkg::hif_desc_type pop_desc
);
   import hif_pkg::*;

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   hif_desc_type     q_ff [Q_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(Q_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_desc  = q_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_desc;
      end
   end

   `include "hex_integer_formatter_unit_assert.svh"

   `HIF_ASSERT_IMP(a_no_push_when_full, push, !full, "job pushed into a full queue")
   `HIF_ASSERT_IMP(a_no_pop_when_empty, pop, pop_valid, "job popped from an empty queue")

endmodule

// ----- src/hif_back.sv -----
// ----------------------------------------------------------------------------
// hif_back
// walks the segments of one job and sends one character beat per cycle while the sink is ready
// ----------------------------------------------------------------------------
module hif_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  hif_pkg::hif_desc_type q_desc,
   output logic                  q_pop,
   hif_rsp_if.source             rsp_chan
);
   import hif_pkg::*;

   bk_state_type state_ff, state_in;
   hif_desc_type cur_ff, cur_in;
   logic [6:0]   rem_ff, rem_in;
   logic         out_valid_ff, out_valid_in;
   logic [7:0]   out_char_ff;
   logic         out_last_ff;
   logic         step;
   logic         gen;
   logic [7:0]   ch;
   logic [2:0]   dig_idx;
   logic [3:0]   nib;

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.character = out_char_ff;
   assign rsp_chan.last      = out_last_ff;

   // current digit, most significant first
   always_comb begin
      dig_idx = 3'(cur_ff.dig_cnt - 4'd1);
      nib     = cur_ff.value[{dig_idx, 2'b00} +: 4];
   end

   // sequencer: load a job, then emit segments in print order
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      q_pop        = 1'b0;
      gen          = 1'b0;
      ch           = CH_SPACE;
      step         = !out_valid_ff || rsp_chan.ready;
      out_valid_in = step ? 1'b0 : out_valid_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_desc;
               rem_in   = q_desc.total;
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (step) begin
               gen          = 1'b1;
               out_valid_in = 1'b1;
               rem_in       = rem_ff - 7'd1;
               if (rem_ff == 7'd1) begin
                  state_in = BK_IDLE;
               end
               if (cur_ff.lead_space) begin
                  ch                = CH_SPACE;
                  cur_in.lead_space = 1'b0;
               end else if (cur_ff.sp_cnt != 6'd0) begin
                  ch            = CH_SPACE;
                  cur_in.sp_cnt = cur_ff.sp_cnt - 6'd1;
               end else if (cur_ff.pfx_cnt == 2'd2) begin
                  ch             = CH_ZERO;
                  cur_in.pfx_cnt = 2'd1;
               end else if (cur_ff.pfx_cnt == 2'd1) begin
                  ch             = cur_ff.upper ? CH_UPPER_X : CH_LOWER_X;
                  cur_in.pfx_cnt = 2'd0;
               end else if (cur_ff.zp_cnt != 6'd0) begin
                  ch            = CH_ZERO;
                  cur_in.zp_cnt = cur_ff.zp_cnt - 6'd1;
               end else if (cur_ff.pz_cnt != 6'd0) begin
                  ch            = CH_ZERO;
                  cur_in.pz_cnt = cur_ff.pz_cnt - 6'd1;
               end else if (cur_ff.dig_cnt != 4'd0) begin
                  ch             = hex_char(nib, cur_ff.upper);
                  cur_in.dig_cnt = cur_ff.dig_cnt - 4'd1;
               end else begin
                  ch            = CH_SPACE;
                  cur_in.tr_cnt = cur_ff.tr_cnt - 6'd1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rem_ff       <= 7'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // job and output beat payload
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (gen) begin
         out_char_ff <= ch;
         out_last_ff <= (rem_ff == 7'd1);
      end
   end

   `include "hex_integer_formatter_unit_assert.svh"

   `HIF_ASSERT_IMP(a_idle_no_rem, state_ff == BK_IDLE, rem_ff == 7'd0, "idle with work left")
   `HIF_ASSERT_NXT(a_last_on_final, gen && rem_ff == 7'd1, out_valid_ff && out_last_ff, "no last")
   `HIF_ASSERT_IMP(a_pop_only_idle, q_pop, state_ff == BK_IDLE && q_valid, "load while busy")

endmodule
